/* src/derq_pkg.sv */
// ----------------------------------------------------------------------------
// derq_pkg
// Shared constants, codes and controller/datapath interface types for the
// double-ended ring queue.
// ----------------------------------------------------------------------------
package derq_pkg;

	localparam int DEF_SLOTS      = 64;
	localparam int DEF_VALUE_BITS = 32;

	localparam int         ME_W     = 6;
	localparam logic [5:0] ME_RESET = 6'd63;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REG_MAX_ENTRIES = 1'b0;

	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd1;
	localparam logic [1:0] CMD_PUSH_REAR  = 2'd2;
	localparam logic [1:0] CMD_POP_REAR   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_now;
		logic load_pend;
	} derq_cmd_t;

	typedef struct packed {
		logic needs_read;
	} derq_sts_t;

endpackage

/* src/derq_ctrl.sv */
// ----------------------------------------------------------------------------
// derq_ctrl
// Sequencer for the ring queue: takes an item, runs at most one memory operation,
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module derq_ctrl
	import derq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  derq_sts_t sts,
	output derq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       load;

	assign out_free = !out_valid_q || !out_stall;
	assign load     = cmd.load_now || cmd.load_pend;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (!sts.needs_read && out_free) begin
					cmd.load_now = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_pend = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_IDLE || state_q == S_DONE))
		else $error("exec state held for more than one cycle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an item still waiting");

	a_out_drop_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(!out_stall))
		else $error("result dropped before it was taken");
`endif

endmodule

/* src/derq_datapath.sv */
// ----------------------------------------------------------------------------
// derq_datapath
// Ring pointers, capacity register, slot memory and result registers for
// the double-ended ring queue.
// ----------------------------------------------------------------------------
module derq_datapath
	import derq_pkg::*;
#(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  derq_cmd_t             cmd,
	output derq_sts_t             sts,
	input  logic [1:0]            cmd_in,
	input  logic [VALUE_BITS-1:0] value_in,
	input  logic                  cfg_we,
	input  logic [ME_W-1:0]       cfg_wdata,
	output logic [ME_W-1:0]       max_entries,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] value_out
);

	localparam int IDX_W = $clog2(SLOTS);

	logic [VALUE_BITS-1:0] mem [SLOTS];

	logic [1:0]            cmd_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [ME_W-1:0]       me_q;
	logic [IDX_W-1:0]      head_q;
	logic [IDX_W-1:0]      tail_q;
	logic [1:0]            status_q;
	logic                  pop_ok_q;
	logic [VALUE_BITS-1:0] rdata_q;
	logic [1:0]            status_out_q;
	logic [VALUE_BITS-1:0] value_out_q;

	logic [IDX_W-1:0] last;
	logic [IDX_W-1:0] head_up;
	logic [IDX_W-1:0] head_dn;
	logic [IDX_W-1:0] tail_up;
	logic [IDX_W-1:0] tail_dn;
	logic [IDX_W-1:0] head_d;
	logic [IDX_W-1:0] tail_d;
	logic [IDX_W-1:0] mem_addr;
	logic             empty;
	logic             full;
	logic             we_raw;
	logic             re_raw;
	logic             mem_we;
	logic             mem_re;
	logic [1:0]       st;

	assign last = (32'(me_q) >= 32'(SLOTS - 1)) ? IDX_W'(SLOTS - 1) : IDX_W'(me_q);

	assign head_up = (head_q == last) ? '0 : head_q + IDX_W'(1);
	assign head_dn = (head_q == '0) ? last : head_q - IDX_W'(1);
	assign tail_up = (tail_q == last) ? '0 : tail_q + IDX_W'(1);
	assign tail_dn = (tail_q == '0) ? last : tail_q - IDX_W'(1);

	assign empty = (head_q == tail_q);
	assign full  = (tail_up == head_q);

	always_comb begin
		st       = ST_OK;
		we_raw   = 1'b0;
		re_raw   = 1'b0;
		mem_addr = head_q;
		head_d   = head_q;
		tail_d   = tail_q;
		unique case (cmd_q)
			CMD_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					we_raw = 1'b1;
					if (empty) begin
						tail_d = tail_up;
					end else begin
						head_d   = head_dn;
						mem_addr = head_dn;
					end
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					re_raw = 1'b1;
					head_d = head_up;
				end
			end
			CMD_PUSH_REAR: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					we_raw   = 1'b1;
					mem_addr = tail_q;
					tail_d   = tail_up;
				end
			end
			CMD_POP_REAR: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					re_raw   = 1'b1;
					mem_addr = tail_dn;
					tail_d   = tail_dn;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign mem_we         = cmd.exec && we_raw;
	assign mem_re         = cmd.exec && re_raw;
	assign sts.needs_read = re_raw;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= value_q;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			me_q   <= ME_RESET;
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_we) begin
			me_q   <= cfg_wdata;
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= cmd_in;
			value_q <= value_in;
		end
		if (cmd.exec) begin
			status_q <= st;
			pop_ok_q <= re_raw;
		end
		if (cmd.load_now) begin
			status_out_q <= st;
			value_out_q  <= '0;
		end else if (cmd.load_pend) begin
			status_out_q <= status_q;
			value_out_q  <= pop_ok_q ? rdata_q : '0;
		end
	end

	assign max_entries = me_q;
	assign status      = status_out_q;
	assign value_out   = value_out_q;

`ifndef SYNTHESIS
	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= last) && (tail_q <= last))
		else $error("ring pointer outside the ring");

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("slot memory read and written by one item");

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(cmd.exec) && !$past(cfg_we)) |-> ($stable(head_q) && $stable(tail_q)))
		else $error("ring pointer moved without an operation");
`endif

endmodule

/* src/double_ended_ring_queue_top.sv */
// ----------------------------------------------------------------------------
// double_ended_ring_queue_top
// Double-ended queue in a ring of slots with one slot kept spare; pushes and
// pops at either end, each item giving a status and, for pops, a value.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    cmd, value_in
//   out      output     out_valid / out_stall  status, value_out
//   cfg      input      APB, pready tied high  max_entries at byte address 0
//
// A pop that finds an item passes through capture, memory read and result load;
// the registered read port of the slot memory makes the separate load step. A push
// or a refused operation is loaded at execute when the output register is free.
// A result waiting in the output register does not stop the next item from
// being taken; it stalls only the load of the following result.
// Reset and writes to max_entries empty the queue; slot contents are kept.
// ----------------------------------------------------------------------------
module double_ended_ring_queue_top
	import derq_pkg::*;
#(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            cmd,
	input  logic [VALUE_BITS-1:0] value_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] value_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	derq_cmd_t       ctl;
	derq_sts_t       sts;
	logic            cfg_we;
	logic            reg_sel;
	logic [ME_W-1:0] max_entries;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_MAX_ENTRIES);
	assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? {{(DATA_W - ME_W){1'b0}}, max_entries} : '0;

	derq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (ctl)
	);

	derq_datapath #(
		.SLOTS      (SLOTS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl),
		.sts         (sts),
		.cmd_in      (cmd),
		.value_in    (value_in),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[ME_W-1:0]),
		.max_entries (max_entries),
		.status      (status),
		.value_out   (value_out)
	);

endmodule
